// ===== src/joystick_debounce_autorepeat_core_assert.svh =====
// Assertion macros used by the joystick debounce top level.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef JOYSTICK_DEBOUNCE_AUTOREPEAT_CORE_ASSERT_SVH
`define JOYSTICK_DEBOUNCE_AUTOREPEAT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define JDA_ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("jda assertion failed");

// Next-cycle implication, disabled while in reset
`define JDA_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jda assertion failed");

`endif

// ===== src/jda_pkg.sv =====
// Shared types and constants for the joystick debounce / auto-repeat core.
// No dependencies.
`default_nettype none

package jda_pkg;

    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int DIR_W     = 3;
    localparam int NOTE_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_CENTRE = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP     = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DN     = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RT     = 3'd4;

    // Note code for "no note"
    localparam logic [NOTE_W-1:0] NO_NOTE = 4'hF;

    // Event kinds
    localparam logic EV_PRESS = 1'b0;
    localparam logic EV_NOTE  = 1'b1;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_STABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_STABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_INTERVAL = 3'd3;

    // Config reset values
    localparam logic [MS_W-1:0] RST_DIR_STABLE   = 16'd40;
    localparam logic [MS_W-1:0] RST_NOTE_STABLE  = 16'd40;
    localparam logic [MS_W-1:0] RST_REP_DELAY    = 16'd500;
    localparam logic [MS_W-1:0] RST_REP_INTERVAL = 16'd130;

    typedef struct packed {
        logic [MS_W-1:0] dir_stable;
        logic [MS_W-1:0] note_stable;
        logic [MS_W-1:0] repeat_delay;
        logic [MS_W-1:0] repeat_interval;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]       now_ms;
        logic                    record_mode;
        logic [DIR_W-1:0]        raw_direction;
        logic signed [NOTE_W-1:0] raw_note;
    } poll_t;

    typedef struct packed {
        logic                     valid;
        logic                     kind;
        logic [DIR_W-1:0]         dir;
        logic signed [NOTE_W-1:0] note;
    } event_t;

endpackage

`default_nettype wire

// ===== src/jda_dir_filter.sv =====
// Direction debounce and up/down auto-repeat state and logic.
// Depends on jda_pkg.
`default_nettype none

module jda_dir_filter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire jda_pkg::poll_t  poll,
    input  wire jda_pkg::cfg_t   cfg,
    output jda_pkg::event_t      evt
);
    import jda_pkg::*;

    logic [DIR_W-1:0]  held_reg, held_next;
    logic [DIR_W-1:0]  cand_reg, cand_next;
    logic [TIME_W-1:0] hold_start_reg, hold_start_next;
    logic [TIME_W-1:0] last_rep_reg, last_rep_next;
    logic [TIME_W-1:0] cand_start_reg, cand_start_next;

    logic [DIR_W-1:0]  dir;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] cand_age;
    logic [TIME_W-1:0] hold_age;
    logic [TIME_W-1:0] rep_age;
    logic              is_vertical;

    // Out-of-range codes count as centre
    assign dir = (poll.raw_direction > DIR_RT) ? DIR_CENTRE : poll.raw_direction;
    assign start_eff = (dir != cand_reg) ? poll.now_ms : cand_start_reg;
    assign cand_age  = poll.now_ms - start_eff;
    assign hold_age  = poll.now_ms - hold_start_reg;
    assign rep_age   = poll.now_ms - last_rep_reg;
    assign is_vertical = (dir == DIR_UP) || (dir == DIR_DN);

    // Next state and press event
    always_comb
    begin
        held_next       = held_reg;
        cand_next       = cand_reg;
        hold_start_next = hold_start_reg;
        last_rep_next   = last_rep_reg;
        cand_start_next = cand_start_reg;
        evt.valid = 1'b0;
        evt.kind  = EV_PRESS;
        evt.dir   = dir;
        evt.note  = NO_NOTE;
        if (step && !poll.record_mode)
        begin
            if (dir == DIR_CENTRE)
            begin
                held_next       = DIR_CENTRE;
                cand_next       = DIR_CENTRE;
                hold_start_next = '0;
                last_rep_next   = '0;
                cand_start_next = '0;
            end
            else if (dir != held_reg)
            begin
                cand_next       = dir;
                cand_start_next = start_eff;
                if (cand_age >= {{(TIME_W-MS_W){1'b0}}, cfg.dir_stable})
                begin
                    held_next       = dir;
                    cand_next       = DIR_CENTRE;
                    hold_start_next = poll.now_ms;
                    last_rep_next   = poll.now_ms;
                    evt.valid       = 1'b1;
                end
            end
            else
            begin
                cand_next = DIR_CENTRE;
                if (is_vertical &&
                    hold_age >= {{(TIME_W-MS_W){1'b0}}, cfg.repeat_delay} &&
                    rep_age >= {{(TIME_W-MS_W){1'b0}}, cfg.repeat_interval})
                begin
                    last_rep_next = poll.now_ms;
                    evt.valid     = 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= DIR_CENTRE;
            cand_reg       <= DIR_CENTRE;
            hold_start_reg <= '0;
            last_rep_reg   <= '0;
            cand_start_reg <= '0;
        end
        else
        begin
            held_reg       <= held_next;
            cand_reg       <= cand_next;
            hold_start_reg <= hold_start_next;
            last_rep_reg   <= last_rep_next;
            cand_start_reg <= cand_start_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/jda_note_filter.sv =====
// Note debounce state and logic for record mode.
// Depends on jda_pkg.
`default_nettype none

module jda_note_filter #(
    parameter int NOTE_COUNT = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire jda_pkg::poll_t  poll,
    input  wire jda_pkg::cfg_t   cfg,
    output jda_pkg::event_t      evt
);
    import jda_pkg::*;

    localparam logic [NOTE_W:0] NOTE_LIM = (NOTE_W+1)'(NOTE_COUNT);

    logic [NOTE_W-1:0] stable_reg, stable_next;
    logic [NOTE_W-1:0] cand_reg, cand_next;
    logic [TIME_W-1:0] cand_start_reg, cand_start_next;

    logic              note_ok;
    logic [NOTE_W-1:0] note;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] cand_age;

    // Anything outside -1 .. NOTE_COUNT-1 reads as no note
    assign note_ok = (poll.raw_note == NO_NOTE) ||
                     (!poll.raw_note[NOTE_W-1] && ({1'b0, poll.raw_note} < NOTE_LIM));
    assign note      = note_ok ? poll.raw_note : NO_NOTE;
    assign start_eff = (note != cand_reg) ? poll.now_ms : cand_start_reg;
    assign cand_age  = poll.now_ms - start_eff;

    // Next state and note-change event
    always_comb
    begin
        stable_next     = stable_reg;
        cand_next       = cand_reg;
        cand_start_next = cand_start_reg;
        evt.valid = 1'b0;
        evt.kind  = EV_NOTE;
        evt.dir   = DIR_CENTRE;
        evt.note  = note;
        if (step)
        begin
            if (poll.record_mode)
            begin
                cand_next       = note;
                cand_start_next = start_eff;
                if (cand_age >= {{(TIME_W-MS_W){1'b0}}, cfg.note_stable} &&
                    note != stable_reg)
                begin
                    stable_next = note;
                    evt.valid   = 1'b1;
                end
            end
            else
            begin
                stable_next     = NO_NOTE;
                cand_next       = NO_NOTE;
                cand_start_next = '0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg     <= NO_NOTE;
            cand_reg       <= NO_NOTE;
            cand_start_reg <= '0;
        end
        else
        begin
            stable_reg     <= stable_next;
            cand_reg       <= cand_next;
            cand_start_reg <= cand_start_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/joystick_debounce_autorepeat_core.sv =====
// Top level: input register, config registers, filters and result register.
// Depends on jda_pkg, jda_dir_filter, jda_note_filter and the assert header.
`default_nettype none
`include "joystick_debounce_autorepeat_core_assert.svh"

// Joystick debounce with typematic repeat. One poll request is taken per clock;
// each poll sits in an input register, passes through one level of compare and
// subtract logic in the direction and note filters, and any event lands in the
// result register, which drives the outputs until the downstream side takes it.
// The sustained rate is one poll per cycle; it drops only while a waiting
// result is stalled downstream, since a poll is processed when the result
// register is free or being emptied.
// Config writes are always ready and take effect on the next poll; write only
// while no poll is in flight.

module joystick_debounce_autorepeat_core #(
    parameter int NOTE_COUNT = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // poll channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [jda_pkg::TIME_W-1:0]          now_ms,
    input  wire logic                                record_mode,
    input  wire logic [jda_pkg::DIR_W-1:0]           raw_direction,
    input  wire logic signed [jda_pkg::NOTE_W-1:0]   raw_note,
    // event channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     event_kind,
    output logic [jda_pkg::DIR_W-1:0]                press_direction,
    output logic signed [jda_pkg::NOTE_W-1:0]        stable_note_out,
    // config write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [jda_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [jda_pkg::MS_W-1:0]            cfg_data
);
    import jda_pkg::*;

    cfg_t   cfg_reg;
    logic   in_valid_reg;
    poll_t  poll_reg;
    logic   out_valid_reg;
    event_t out_reg;

    logic   process;
    event_t dir_evt;
    event_t note_evt;
    event_t evt;
    logic   out_is_press;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dir_stable      <= RST_DIR_STABLE;
            cfg_reg.note_stable     <= RST_NOTE_STABLE;
            cfg_reg.repeat_delay    <= RST_REP_DELAY;
            cfg_reg.repeat_interval <= RST_REP_INTERVAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIR_STABLE:   cfg_reg.dir_stable      <= cfg_data;
                CFG_NOTE_STABLE:  cfg_reg.note_stable     <= cfg_data;
                CFG_REP_DELAY:    cfg_reg.repeat_delay    <= cfg_data;
                CFG_REP_INTERVAL: cfg_reg.repeat_interval <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Handshake: a held poll is processed unless a result is stuck downstream
    assign process  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !process;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            poll_reg.now_ms        <= now_ms;
            poll_reg.record_mode   <= record_mode;
            poll_reg.raw_direction <= raw_direction;
            poll_reg.raw_note      <= raw_note;
        end
    end

    // Filters
    jda_dir_filter u_dir (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process),
        .poll  (poll_reg),
        .cfg   (cfg_reg),
        .evt   (dir_evt)
    );

    jda_note_filter #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_note (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process),
        .poll  (poll_reg),
        .cfg   (cfg_reg),
        .evt   (note_evt)
    );

    assign evt = poll_reg.record_mode ? note_evt : dir_evt;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (process && evt.valid)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (process && evt.valid)
            out_reg <= evt;
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = out_reg.kind;
    assign press_direction = out_reg.dir;
    assign stable_note_out = out_reg.note;

    assign out_is_press = out_valid_reg && (out_reg.kind == EV_PRESS);

    // Checks
    `JDA_ASSERT_SAME(a_no_overwrite, clk, rst_n, process, !(out_valid_reg && out_stall))
    `JDA_ASSERT_SAME(a_stall_needs_item, clk, rst_n, in_stall, in_valid_reg)
    `JDA_ASSERT_NEXT(a_event_captured, clk, rst_n, process && evt.valid, out_valid_reg)
    `JDA_ASSERT_SAME(a_press_has_dir, clk, rst_n, out_is_press, out_reg.dir != DIR_CENTRE)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for joystick_debounce_autorepeat_core: directed polls, then
// random poll sequences under several register settings, checked against a local predictor.
// Depends on jda_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
    import jda_pkg::*;

    localparam int NOTE_COUNT    = 8;
    localparam int CLK_PERIOD    = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_POLLS   = 165;
    localparam int SCRIPT_ROWS   = 25;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRINT_CAP     = 40;

    // Codes the package does not name
    localparam logic [DIR_W-1:0] DIR_LT     = 3'd3;
    localparam logic [DIR_W-1:0] DIR_BAD_HI = 3'd7;
    localparam int CFG_FIRST_UNUSED = 4;
    localparam int CFG_LAST_INDEX   = (1 << CFG_IDX_W) - 1;

    // How a directed row is checked
    typedef enum logic [1:0] {ROW_QUIET, ROW_EVENT, ROW_MODEL} row_check_e;

    typedef struct {
        logic [TIME_W-1:0]        stamp;
        logic                     rec;
        logic [DIR_W-1:0]         dir;
        logic signed [NOTE_W-1:0] note;
        row_check_e               check;
        logic                     ev_kind;
        logic [DIR_W-1:0]         ev_dir;
        logic signed [NOTE_W-1:0] ev_note;
    } script_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [TIME_W-1:0]        now_ms = '0;
    logic                     record_mode = 1'b0;
    logic [DIR_W-1:0]         raw_direction = '0;
    logic signed [NOTE_W-1:0] raw_note = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     event_kind;
    logic [DIR_W-1:0]         press_direction;
    logic signed [NOTE_W-1:0] stable_note_out;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [MS_W-1:0]          cfg_data = '0;

    joystick_debounce_autorepeat_core #(
        .NOTE_COUNT(NOTE_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .now_ms(now_ms),
        .record_mode(record_mode),
        .raw_direction(raw_direction),
        .raw_note(raw_note),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .press_direction(press_direction),
        .stable_note_out(stable_note_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Predictor state: timing registers plus filter state
    cfg_t                     timing;
    logic [DIR_W-1:0]         held_dir;
    logic [DIR_W-1:0]         cand_dir;
    logic [TIME_W-1:0]        hold_start;
    logic [TIME_W-1:0]        last_repeat;
    logic [TIME_W-1:0]        cand_dir_start;
    logic signed [NOTE_W-1:0] held_note;
    logic signed [NOTE_W-1:0] cand_note;
    logic [TIME_W-1:0]        cand_note_start;

    event_t pending_events[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    bit     steady_send = 1'b0;

    // One poll through the debounce / repeat filters; valid set when a press or note fires
    function automatic event_t advance_debounce(poll_t p);
        event_t                   ev;
        logic [DIR_W-1:0]         d;
        logic signed [NOTE_W-1:0] nt;
        logic [TIME_W-1:0]        held_for;
        logic [TIME_W-1:0]        since_rep;
        int                       nv;
        ev = '0;
        ev.note = NO_NOTE;
        if (p.record_mode)
        begin
            nv = $signed(p.raw_note);
            nt = (nv < -1 || nv >= NOTE_COUNT) ? NO_NOTE : p.raw_note;
            if (nt != cand_note)
            begin
                cand_note = nt;
                cand_note_start = p.now_ms;
            end
            held_for = p.now_ms - cand_note_start;
            if (held_for >= timing.note_stable && nt != held_note)
            begin
                held_note = nt;
                ev.valid = 1'b1;
                ev.kind = EV_NOTE;
                ev.dir = DIR_CENTRE;
                ev.note = nt;
            end
            return ev;
        end

        // direction mode always drops the note filter
        held_note = NO_NOTE;
        cand_note = NO_NOTE;
        cand_note_start = '0;

        d = p.raw_direction;
        if (d > DIR_RT)
            d = DIR_CENTRE;
        if (d == DIR_CENTRE)
        begin
            held_dir = DIR_CENTRE;
            cand_dir = DIR_CENTRE;
            hold_start = '0;
            last_repeat = '0;
            cand_dir_start = '0;
            return ev;
        end

        // new direction: debounce before the first press
        if (d != held_dir)
        begin
            if (d != cand_dir)
            begin
                cand_dir = d;
                cand_dir_start = p.now_ms;
            end
            held_for = p.now_ms - cand_dir_start;
            if (held_for >= timing.dir_stable)
            begin
                held_dir = d;
                cand_dir = DIR_CENTRE;
                hold_start = p.now_ms;
                last_repeat = p.now_ms;
                ev.valid = 1'b1;
                ev.kind = EV_PRESS;
                ev.dir = d;
            end
            return ev;
        end

        // held: only up and down repeat
        cand_dir = DIR_CENTRE;
        held_for = p.now_ms - hold_start;
        since_rep = p.now_ms - last_repeat;
        if ((d == DIR_UP || d == DIR_DN) && held_for >= timing.repeat_delay &&
            since_rep >= timing.repeat_interval)
        begin
            last_repeat = p.now_ms;
            ev.valid = 1'b1;
            ev.kind = EV_PRESS;
            ev.dir = d;
        end
        return ev;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Register write request; valid stays high so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DIR_STABLE:   timing.dir_stable = val;
            CFG_NOTE_STABLE:  timing.note_stable = val;
            CFG_REP_DELAY:    timing.repeat_delay = val;
            CFG_REP_INTERVAL: timing.repeat_interval = val;
            default: ;
        endcase
    endtask

    // Sender idle: mostly none, some short, a few long
    task automatic sender_pause();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!steady_send)
        begin
            if (r >= 95)
                n = $urandom_range(10, 40);
            else if (r >= 70)
                n = $urandom_range(1, 3);
        end
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Poll request; returns once accepted, with the predicted event
    task automatic send_poll(input poll_t p, output event_t predicted);
        now_ms <= p.now_ms;
        record_mode <= p.record_mode;
        raw_direction <= p.raw_direction;
        raw_note <= p.raw_note;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_debounce(p);
    endtask

    // Let all expected events arrive, then allow for polls still in the pipe
    task automatic drain_events();
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver stall: quiet stretches, short blips and occasional long holds
    int stall_left = 0;
    int calm_left = 0;
    int stall_roll;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 10)
                calm_left = $urandom_range(20, 200);
            else if (stall_roll < 14)
                stall_left = $urandom_range(10, 50);
            else if (stall_roll < 40)
                stall_left = $urandom_range(0, 3);
            out_stall <= 1'b0;
        end
    end

    // Event checker
    event_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
                flag_mismatch($sformatf("unexpected event kind=%0d dir=%0d note=%0d",
                              event_kind, press_direction, stable_note_out));
            else
            begin
                want = pending_events.pop_front();
                if (event_kind !== want.kind)
                    flag_mismatch($sformatf("event_kind %0d, want %0d",
                                  event_kind, want.kind));
                if (press_direction !== want.dir)
                    flag_mismatch($sformatf("press_direction %0d, want %0d",
                                  press_direction, want.dir));
                if (stable_note_out !== want.note)
                    flag_mismatch($sformatf("stable_note_out %0d, want %0d",
                                  stable_note_out, want.note));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    script_row_t script [SCRIPT_ROWS];
    cfg_t        phase_cfg [PHASES];

    initial
    begin
        poll_t             p;
        event_t            ev;
        event_t            typed;
        logic [TIME_W-1:0] stamp;
        logic              cur_rec;
        logic [DIR_W-1:0]  cur_dir;
        logic [NOTE_W-1:0] cur_note;
        int                scale;
        int                r;

        // Register reset values and cleared filter state
        timing = '{RST_DIR_STABLE, RST_NOTE_STABLE, RST_REP_DELAY, RST_REP_INTERVAL};
        held_dir = DIR_CENTRE;
        cand_dir = DIR_CENTRE;
        hold_start = '0;
        last_repeat = '0;
        cand_dir_start = '0;
        held_note = NO_NOTE;
        cand_note = NO_NOTE;
        cand_note_start = '0;

        // Directed polls under reset timing (40 / 40 / 500 / 130)
        script = '{
            '{32'd100,  1'b0, DIR_UP,     NO_NOTE, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd140,  1'b0, DIR_UP,     NO_NOTE, ROW_EVENT, EV_PRESS, DIR_UP,     NO_NOTE},
            '{32'd639,  1'b0, DIR_UP,     4'sd0,   ROW_MODEL, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd640,  1'b0, DIR_UP,     4'sd0,   ROW_MODEL, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd769,  1'b0, DIR_UP,     4'sd7,   ROW_MODEL, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd770,  1'b0, DIR_UP,     4'sd7,   ROW_MODEL, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd800,  1'b0, DIR_CENTRE, 4'b1000, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd800,  1'b0, DIR_LT,     NO_NOTE, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd840,  1'b0, DIR_LT,     NO_NOTE, ROW_EVENT, EV_PRESS, DIR_LT,     NO_NOTE},
            // left held far past the repeat delay: no repeat
            '{32'd5000, 1'b0, DIR_LT,     NO_NOTE, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            // out-of-range direction code acts as centre
            '{32'd5000, 1'b0, DIR_BAD_HI, NO_NOTE, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd5000, 1'b0, DIR_RT,     NO_NOTE, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd5040, 1'b0, DIR_RT,     NO_NOTE, ROW_EVENT, EV_PRESS, DIR_RT,     NO_NOTE},
            '{32'd5050, 1'b1, DIR_UP,     4'sd7,   ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd5090, 1'b1, DIR_UP,     4'sd7,   ROW_EVENT, EV_NOTE,  DIR_CENTRE, 4'sd7},
            // note below range acts as no note
            '{32'd5100, 1'b1, DIR_BAD_HI, 4'b1000, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd5140, 1'b1, DIR_BAD_HI, 4'b1000, ROW_EVENT, EV_NOTE,  DIR_CENTRE, NO_NOTE},
            '{32'd5150, 1'b1, DIR_CENTRE, 4'sd0,   ROW_MODEL, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd5190, 1'b1, DIR_CENTRE, 4'sd0,   ROW_MODEL, EV_PRESS, DIR_CENTRE, NO_NOTE},
            // right still held across record mode
            '{32'd5200, 1'b0, DIR_RT,     4'sd3,   ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd5200, 1'b0, DIR_DN,     NO_NOTE, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'd5240, 1'b0, DIR_DN,     NO_NOTE, ROW_EVENT, EV_PRESS, DIR_DN,     NO_NOTE},
            // timestamp wrap
            '{32'hFFFF_FFF0, 1'b0, DIR_CENTRE, NO_NOTE, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'hFFFF_FFF0, 1'b0, DIR_UP,     NO_NOTE, ROW_QUIET, EV_PRESS, DIR_CENTRE, NO_NOTE},
            '{32'h0000_0018, 1'b0, DIR_UP,     NO_NOTE, ROW_EVENT, EV_PRESS, DIR_UP,     NO_NOTE}
        };

        // Timing per random phase, extremes first
        phase_cfg[0] = '{16'd0, 16'd0, 16'd0, 16'd0};
        phase_cfg[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        phase_cfg[2] = '{RST_DIR_STABLE, RST_NOTE_STABLE, RST_REP_DELAY, RST_REP_INTERVAL};
        phase_cfg[3] = '{16'd1, 16'd1, 16'd1, 16'd1};
        phase_cfg[4] = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF};
        phase_cfg[5] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
        phase_cfg[6] = '{16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                         16'($urandom_range(0, 600)), 16'($urandom_range(0, 200))};
        phase_cfg[7] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            sender_pause();
            p.now_ms = script[i].stamp;
            p.record_mode = script[i].rec;
            p.raw_direction = script[i].dir;
            p.raw_note = script[i].note;
            send_poll(p, ev);
            if (script[i].check == ROW_MODEL)
            begin
                if (ev.valid)
                    pending_events.push_back(ev);
            end
            else if (script[i].check == ROW_EVENT)
            begin
                typed.valid = 1'b1;
                typed.kind = script[i].ev_kind;
                typed.dir = script[i].ev_dir;
                typed.note = script[i].ev_note;
                pending_events.push_back(typed);
            end
        end
        in_valid <= 1'b0;
        drain_events();

        stamp = $urandom;
        cur_rec = 1'b0;
        cur_dir = DIR_UP;
        cur_note = NO_NOTE;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Registers change only with nothing in flight
            write_reg(CFG_DIR_STABLE, phase_cfg[ph].dir_stable);
            write_reg(CFG_NOTE_STABLE, phase_cfg[ph].note_stable);
            write_reg(CFG_REP_DELAY, phase_cfg[ph].repeat_delay);
            write_reg(CFG_REP_INTERVAL, phase_cfg[ph].repeat_interval);
            write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_INDEX, CFG_FIRST_UNUSED)),
                      16'($urandom));
            cfg_valid <= 1'b0;

            steady_send = (ph % 3 == 1);
            scale = 8;
            if (int'(phase_cfg[ph].dir_stable) / 6 > scale)
                scale = int'(phase_cfg[ph].dir_stable) / 6;
            if (int'(phase_cfg[ph].note_stable) / 6 > scale)
                scale = int'(phase_cfg[ph].note_stable) / 6;
            if (int'(phase_cfg[ph].repeat_delay) / 6 > scale)
                scale = int'(phase_cfg[ph].repeat_delay) / 6;
            if (int'(phase_cfg[ph].repeat_interval) / 6 > scale)
                scale = int'(phase_cfg[ph].repeat_interval) / 6;

            for (int n = 0; n < PHASE_POLLS; n++)
            begin
                // Held input with occasional change of mode, direction or note
                if ($urandom_range(0, 9) == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        cur_rec = ~cur_rec;
                    cur_dir = ($urandom_range(0, 9) == 0) ? DIR_W'($urandom)
                                                         : DIR_W'($urandom_range(0, 4));
                    cur_note = ($urandom_range(0, 7) == 0) ? NOTE_W'($urandom)
                                                          : NOTE_W'($urandom_range(0, 8) - 1);
                end
                p.record_mode = cur_rec;
                p.raw_direction = cur_rec ? DIR_W'($urandom) : cur_dir;
                p.raw_note = cur_rec ? cur_note : NOTE_W'($urandom);
                // one-poll glitch
                if ($urandom_range(0, 9) == 0)
                begin
                    p.raw_direction = DIR_W'($urandom);
                    p.raw_note = NOTE_W'($urandom);
                end

                // Time step: mostly small, some near a threshold, some repeated, some wild
                r = $urandom_range(0, 99);
                if (r < 65)
                    stamp += TIME_W'($urandom_range(0, scale));
                else if (r < 82)
                begin
                    case ($urandom_range(0, 3))
                        0: stamp += TIME_W'(phase_cfg[ph].dir_stable);
                        1: stamp += TIME_W'(phase_cfg[ph].note_stable);
                        2: stamp += TIME_W'(phase_cfg[ph].repeat_delay);
                        default: stamp += TIME_W'(phase_cfg[ph].repeat_interval);
                    endcase
                    stamp += TIME_W'($urandom_range(0, 1));
                end
                else if (r < 95)
                    ;
                else
                    stamp = $urandom;
                p.now_ms = stamp;

                sender_pause();
                send_poll(p, ev);
                if (ev.valid)
                    pending_events.push_back(ev);
            end
            in_valid <= 1'b0;
            drain_events();
        end

        if (pending_events.size() != 0)
            flag_mismatch($sformatf("%0d events never arrived", pending_events.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
